>>> src/pctd_pkg.sv
// Package: shared widths, limits, controller states and command/status structs.
`timescale 1ns / 1ps
package pctd_pkg;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 11;
    localparam int NUM_W    = 31;   // magnitude bits of a non-negative value
    localparam int DIV_W    = 16;   // trial divisor, at most 46341
    localparam int SQ_W     = 32;   // divisor squared
    localparam int BITCNT_W = 5;    // indexes the NUM_W bits of the serial remainder

    // Largest value the count field can hold
    localparam int COUNT_MAX = 2047;

    // First trial divisor and its square
    localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(2);
    localparam logic [SQ_W-1:0]  FIRST_SQ  = SQ_W'(4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD,
        ST_TEST,
        ST_PUBLISH
    } pctd_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture input item, reset divisor to 2
        logic mod_start;  // begin serial remainder
        logic mod_step;   // one remainder bit
        logic div_next;   // advance divisor and its square
        logic publish;    // load result register and update count
        logic verdict;    // prime flag for publish
    } pctd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic trivial;    // negative, zero or one
        logic sq_above;   // divisor squared exceeds value
        logic mod_done;   // current step is the last remainder bit
        logic rem_zero;   // remainder is zero
        logic out_full;   // result register holds an untaken result
    } pctd_status_t;

endpackage

>>> src/pctd_if.sv
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface pctd_item_if;
    logic                                valid;
    logic                                ready;
    logic signed [pctd_pkg::VALUE_W-1:0] value;
    logic                                last_element;

    modport source (output valid, output value, output last_element, input ready);
    modport sink   (input valid, input value, input last_element, output ready);
endinterface

interface pctd_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 is_prime;
    logic [pctd_pkg::COUNT_W-1:0]         prime_count;
    logic                                 count_final;

    modport source (output valid, output is_prime, output prime_count, output count_final,
                    input ready);
    modport sink   (input valid, input is_prime, input prime_count, input count_final,
                    output ready);
endinterface

>>> src/prime_counter_trial_division_core.sv
// Top level: trial-division prime tester with per-matrix running prime count.
//
//   channel  dir  payload                                   transfer
//   item     in   value[31:0] signed, last_element          valid && ready
//   result   out  is_prime, prime_count[10:0], count_final  valid && ready
//
// Each divisor d is tried in turn: a compare of d*d against the value, the bit-serial
// remainder over the 31 magnitude bits of the value, then a test of that remainder.
// Reset (rst_n low) clears the controller, the running count and result valid.
// An item is taken whenever the controller is idle, even while a result waits;
// the next result waits in the controller until the result register is free.
`timescale 1ns / 1ps
module prime_counter_trial_division_core #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    pctd_item_if.sink     item,
    pctd_result_if.source result
);
    import pctd_pkg::*;

    pctd_cmd_t    cmd;
    pctd_status_t status;

    pctd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    pctd_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (item.value),
        .last_element (item.last_element),
        .cmd          (cmd),
        .status       (status),
        .result       (result)
    );

endmodule

>>> src/pctd_datapath.sv
// Datapath: operand, divisor/square, serial remainder, running count and result register.
`timescale 1ns / 1ps
module pctd_datapath #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [pctd_pkg::VALUE_W-1:0] value,
    input  logic                                last_element,
    input  pctd_pkg::pctd_cmd_t                 cmd,
    output pctd_pkg::pctd_status_t              status,
    pctd_result_if.source                       result
);
    import pctd_pkg::*;

    localparam int CountCapInt = (MAX_ELEMENTS > COUNT_MAX) ? COUNT_MAX : MAX_ELEMENTS;
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CountCapInt);

    logic [NUM_W-1:0]    num_reg;
    logic                trivial_reg;
    logic                last_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    shift_reg;
    logic [BITCNT_W-1:0] bit_reg;
    logic [COUNT_W-1:0]  running_reg;
    logic                out_valid_reg;
    logic                out_prime_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_final_reg;

    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      trial_diff;
    logic [DIV_W-1:0]    rem_next;
    logic [COUNT_W-1:0]  count_next;

    // One restoring step: shift in the next value bit, subtract divisor if it fits
    always_comb
    begin
        trial      = {rem_reg, shift_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = trial_diff[DIV_W-1:0];
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    // Saturating count including this item
    always_comb
    begin
        if (cmd.verdict && (running_reg < COUNT_CAP))
        begin
            count_next = running_reg + COUNT_W'(1);
        end
        else
        begin
            count_next = running_reg;
        end
    end

    // Operand, divisor and remainder registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg     <= value[NUM_W-1:0];
            trivial_reg <= value[VALUE_W-1] || (value[NUM_W-1:1] == '0);
            last_reg    <= last_element;
        end
        if (cmd.load)
        begin
            div_reg <= FIRST_DIV;
            sq_reg  <= FIRST_SQ;
        end
        else if (cmd.div_next)
        begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_reg  <= sq_reg + SQ_W'({div_reg, 1'b1});
            div_reg <= div_reg + DIV_W'(1);
        end
        if (cmd.mod_start)
        begin
            rem_reg   <= '0;
            shift_reg <= num_reg;
            bit_reg   <= BITCNT_W'(NUM_W - 1);
        end
        else if (cmd.mod_step)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[NUM_W-2:0], 1'b0};
            bit_reg   <= bit_reg - BITCNT_W'(1);
        end
    end

    // Running count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.publish)
            begin
                running_reg   <= last_reg ? '0 : count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_prime_reg <= cmd.verdict;
            out_count_reg <= count_next;
            out_final_reg <= last_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.is_prime    = out_prime_reg;
    assign result.prime_count = out_count_reg;
    assign result.count_final = out_final_reg;

    assign status.trivial  = trivial_reg;
    assign status.sq_above = sq_reg > {1'b0, num_reg};
    assign status.mod_done = (bit_reg == '0);
    assign status.rem_zero = (rem_reg == '0);
    assign status.out_full = out_valid_reg && !result.ready;

    // A publish never overwrites an untaken result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !(out_valid_reg && !result.ready))
        else $error("result register overwritten");

    // Remainder stays below the divisor after each step
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_step |=> (rem_reg < div_reg))
        else $error("remainder not reduced");

    // Count never exceeds its cap
    assert property (@(posedge clk) disable iff (!rst_n)
        running_reg <= COUNT_CAP)
        else $error("running count above cap");

endmodule

>>> src/pctd_ctrl.sv
// Controller: sequences load, divisor checks, serial remainder and result publish.
`timescale 1ns / 1ps
module pctd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  pctd_pkg::pctd_status_t status,
    output pctd_pkg::pctd_cmd_t    cmd
);
    import pctd_pkg::*;

    pctd_state_t state_reg;
    pctd_state_t state_next;
    logic        verdict_reg;
    logic        verdict_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            verdict_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        verdict_next  = verdict_reg;
        item_ready    = 1'b0;
        cmd           = '0;
        cmd.verdict   = verdict_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.trivial)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_PUBLISH;
                end
                else if (status.sq_above)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_PUBLISH;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_done)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.rem_zero)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_PUBLISH;
                end
                else
                begin
                    cmd.div_next = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_PUBLISH:
            begin
                if (!status.out_full)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Values below two publish as not prime
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && status.trivial) |=>
            (state_reg == ST_PUBLISH && !verdict_reg))
        else $error("trivial value not rejected");

    // A zero remainder ends the search as composite
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST && status.rem_zero) |=>
            (state_reg == ST_PUBLISH && !verdict_reg))
        else $error("divisor found but not rejected");

    // A new item is loaded only from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE && item_ready))
        else $error("load outside idle");

endmodule

>>> bench/tb_top.sv
// Testbench: prime flags and per-matrix prime counts of the trial-division core.
`timescale 1ns / 1ps
module tb_top;
    import pctd_pkg::*;

    localparam int MAX_ELEMENTS = 1024;
    localparam int COUNT_CAP    = (MAX_ELEMENTS < COUNT_MAX) ? MAX_ELEMENTS : COUNT_MAX;
    localparam int IDLE_PCT     = 25;
    localparam int SETTLE_CYC   = 200;
    localparam int BURST_FIRST  = 30;   // no idling on either side within this stretch
    localparam int BURST_LAST   = 60;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last_element;
    } element_t;

    typedef struct {
        logic               is_prime;
        logic [COUNT_W-1:0] prime_count;
        logic               count_final;
    } verdict_t;

    logic clk;
    logic rst_n;

    pctd_item_if   item_ch ();
    pctd_result_if res_ch ();

    element_t pending_items[$];
    verdict_t expected_verdicts[$];

    logic [COUNT_W-1:0] primes_so_far;
    int                 items_sent;
    int                 results_seen;
    int                 mismatch_count;
    element_t           next_item;
    verdict_t           want;

    prime_counter_trial_division_core #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    // Clock and reset
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        fork
            forever #2 clk = ~clk;
            begin
                repeat (8) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // Run limit
    initial
    begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Plain trial division, divisors while d*d <= n
    function automatic logic value_is_prime(input logic signed [VALUE_W-1:0] v);
        longint n;
        longint d;
        if (v < 0)
            return 1'b0;
        n = longint'(v);
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Expected result of one transferred element; updates the running count
    task automatic count_prime(input logic signed [VALUE_W-1:0] v, input logic last);
        verdict_t r;
        logic [COUNT_W-1:0] cnt;
        r.is_prime = value_is_prime(v);
        cnt = primes_so_far;
        if (r.is_prime && cnt < COUNT_W'(COUNT_CAP))
            cnt = cnt + COUNT_W'(1);
        r.prime_count = cnt;
        r.count_final = last;
        expected_verdicts.push_back(r);
        primes_so_far = last ? '0 : cnt;
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        int sel;
        logic [31:0] raw;
        sel = $urandom_range(0, 99);
        raw = $urandom;
        if (sel < 30)
            return VALUE_W'($urandom_range(0, 255));
        else if (sel < 50)
            return VALUE_W'($urandom_range(256, 65535));
        else if (sel < 65)
            return {1'b1, raw[30:0]};                       // negative
        else if (sel < 80)
            return {1'b0, raw[30:1], 1'b0};                 // large even, quick reject
        else if (sel < 92)
            return VALUE_W'(3 * $urandom_range(1, 715827882)); // large multiple of three
        else
            return VALUE_W'($urandom_range(65536, 1048575));
    endfunction

    task automatic add_element(input logic signed [VALUE_W-1:0] v, input logic last);
        element_t e;
        e.value        = v;
        e.last_element = last;
        pending_items.push_back(e);
    endtask

    // Item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid        <= 1'b0;
            item_ch.value        <= '0;
            item_ch.last_element <= 1'b0;
            primes_so_far        = '0;
            items_sent           = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                count_prime(item_ch.value, item_ch.last_element);
                items_sent++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_items.size() != 0 &&
                    ((items_sent >= BURST_FIRST && items_sent < BURST_LAST) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_item = pending_items.pop_front();
                    item_ch.valid        <= 1'b1;
                    item_ch.value        <= next_item.value;
                    item_ch.last_element <= next_item.last_element;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            results_seen = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch("result transfer with nothing expected");
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (res_ch.is_prime !== want.is_prime)
                        report_mismatch($sformatf("result %0d is_prime %b, want %b",
                            results_seen, res_ch.is_prime, want.is_prime));
                    if (res_ch.prime_count !== want.prime_count)
                        report_mismatch($sformatf("result %0d prime_count %0d, want %0d",
                            results_seen, res_ch.prime_count, want.prime_count));
                    if (res_ch.count_final !== want.count_final)
                        report_mismatch($sformatf("result %0d count_final %b, want %b",
                            results_seen, res_ch.count_final, want.count_final));
                end
            end
            res_ch.ready <= (results_seen >= BURST_FIRST && results_seen < BURST_LAST) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus and end of run
    initial
    begin
        int mat_len;
        int k;
        int small_primes[6];
        small_primes = '{2, 3, 5, 7, 11, 13};
        mismatch_count = 0;

        // Directed: edge values, small and square cases, the largest prime
        add_element(0, 1'b0);
        add_element(1, 1'b0);
        add_element(2, 1'b0);
        add_element(3, 1'b0);
        add_element(4, 1'b0);
        add_element(-1, 1'b0);
        add_element(32'sh8000_0000, 1'b0);
        add_element(9, 1'b0);
        add_element(25, 1'b0);
        add_element(49, 1'b0);
        add_element(63001, 1'b0);          // 251 squared
        add_element(65521, 1'b0);
        add_element(32'sh7FFF_FFFF, 1'b0); // largest value, prime
        add_element(32'sh7FFF_FFFE, 1'b0);
        add_element(32'sh4000_0000, 1'b0);
        add_element(97, 1'b1);
        add_element(2, 1'b1);              // one-element matrix
        add_element(-7, 1'b1);
        add_element(17, 1'b0);
        add_element(19, 1'b1);

        // Run of small primes in one matrix, back-to-back counting
        for (k = 0; k < 16; k++)
            add_element(small_primes[$urandom_range(0, 5)], 1'b0);
        add_element(1, 1'b0);
        add_element(3, 1'b1);

        // Random matrices of random length
        k = 0;
        while (k < 60)
        begin
            mat_len = $urandom_range(1, 12);
            repeat (mat_len)
            begin
                k++;
                add_element(random_value(), 1'b0);
            end
            pending_items[pending_items.size()-1].last_element = 1'b1;
            // occasional early last flag inside a matrix
            if ($urandom_range(0, 9) == 0)
                pending_items[pending_items.size()-1-$urandom_range(0, mat_len-1)]
                    .last_element = 1'b1;
        end

        @(posedge rst_n);
        while (pending_items.size() != 0 || item_ch.valid)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
